// ===== hdl/wntm_pkg.sv =====
// Shared constants, command codes and control types of the timestamp matcher.
package wntm_pkg;

    localparam int STAMP_W    = 52;
    localparam int GAP_W      = 32;
    localparam int CMD_W      = 2;
    localparam int OUT_IDX_W  = 12;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 120;

    localparam int TABLE_DEPTH_DEF = 4096;
    localparam int LOOK_BEHIND_DEF = 10;
    localparam int LOOK_AHEAD_DEF  = 20;

    localparam logic [GAP_W-1:0] MAX_GAP_RESET = 32'd20000;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MATCH  = 2'd2;

    // controls the compare pipeline for one table word
    typedef struct packed {
        logic start;   // new search: drop the running best
        logic valid;   // table word on the read port belongs to the window
    } pick_ctl_t;

endpackage

// ===== hdl/wntm_table.sv =====
// Depth timestamp table: one write port, one read port with registered data.
module wntm_table #(
    parameter int DEPTH = wntm_pkg::TABLE_DEPTH_DEF,
    parameter int IW    = $clog2(wntm_pkg::TABLE_DEPTH_DEF)
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [IW-1:0]                wr_addr,
    input  logic [wntm_pkg::STAMP_W-1:0] wr_data,
    input  logic                         rd_en,
    input  logic [IW-1:0]                rd_addr,
    output logic [wntm_pkg::STAMP_W-1:0] rd_data
);

    logic [wntm_pkg::STAMP_W-1:0] mem [DEPTH];
    logic [wntm_pkg::STAMP_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/wntm_pick.sv =====
// Nearest-entry tracker: absolute difference stage, then running minimum.
module wntm_pick #(
    parameter int IW = $clog2(wntm_pkg::TABLE_DEPTH_DEF)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  wntm_pkg::pick_ctl_t          ctl,
    input  logic [IW-1:0]                rd_idx,
    input  logic [wntm_pkg::STAMP_W-1:0] rd_data,
    input  logic [wntm_pkg::STAMP_W-1:0] color,
    output logic                         busy,
    output logic                         have,
    output logic [IW-1:0]                best_idx,
    output logic [wntm_pkg::STAMP_W-1:0] best_stamp,
    output logic [wntm_pkg::STAMP_W-1:0] best_gap
);

    logic                         dif_valid_reg;
    logic [wntm_pkg::STAMP_W-1:0] dif_reg;
    logic [wntm_pkg::STAMP_W-1:0] dif_stamp_reg;
    logic [IW-1:0]                dif_idx_reg;
    logic [wntm_pkg::STAMP_W-1:0] dif_next;

    logic                         have_reg;
    logic [IW-1:0]                best_idx_reg;
    logic [wntm_pkg::STAMP_W-1:0] best_stamp_reg;
    logic [wntm_pkg::STAMP_W-1:0] best_gap_reg;
    logic                         better;

    always_comb
    begin
        if (color >= rd_data)
        begin
            dif_next = color - rd_data;
        end
        else
        begin
            dif_next = rd_data - color;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dif_valid_reg <= 1'b0;
        end
        else
        begin
            dif_valid_reg <= ctl.valid && !ctl.start;
        end
    end

    always_ff @(posedge clk)
    begin
        dif_reg       <= dif_next;
        dif_stamp_reg <= rd_data;
        dif_idx_reg   <= rd_idx;
    end

    // strict less-than keeps the earliest entry on a tie
    assign better = dif_valid_reg && (!have_reg || (dif_reg < best_gap_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg       <= 1'b0;
            best_idx_reg   <= '0;
            best_stamp_reg <= '0;
            best_gap_reg   <= '0;
        end
        else if (ctl.start)
        begin
            have_reg       <= 1'b0;
            best_idx_reg   <= '0;
            best_stamp_reg <= '0;
            best_gap_reg   <= '0;
        end
        else if (better)
        begin
            have_reg       <= 1'b1;
            best_idx_reg   <= dif_idx_reg;
            best_stamp_reg <= dif_stamp_reg;
            best_gap_reg   <= dif_reg;
        end
    end

    assign busy       = dif_valid_reg;
    assign have       = have_reg;
    assign best_idx   = best_idx_reg;
    assign best_stamp = best_stamp_reg;
    assign best_gap   = best_gap_reg;

endmodule

// ===== hdl/windowed_nearest_timestamp_matcher.sv =====
// Top level of the windowed nearest-timestamp matcher.
//
//  channel  | dir | handshake         | contents
//  s_*      | in  | s_tvalid/s_tready | tuser command, tdata depth or color stamp
//  m_*      | out | m_tvalid/m_tready | tuser matched, tdata index/stamp/gap
//  cfg_*    | in  | cfg_wr_en         | max_gap register
//
// Clear, append and unused commands complete in the idle state.
// A match reads the window, at most LOOK_BEHIND + LOOK_AHEAD entries, one table
// word per cycle from the table's single read port; an empty window issues no reads.
// Reset empties the table and centers the cursor at 0; max_gap goes to 20000.
// One word is worked on at a time; a pending result in the output register
// stalls only the end of the next match, not its scan.
module windowed_nearest_timestamp_matcher #(
    parameter int TABLE_DEPTH = wntm_pkg::TABLE_DEPTH_DEF,
    parameter int LOOK_BEHIND = wntm_pkg::LOOK_BEHIND_DEF,
    parameter int LOOK_AHEAD  = wntm_pkg::LOOK_AHEAD_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [wntm_pkg::S_TDATA_W-1:0] s_tdata,   // [51:0] stamp
    input  logic [wntm_pkg::CMD_W-1:0]     s_tuser,   // [1:0] command
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [11:0] depth_index, [63:12] depth_stamp, [115:64] gap
    output logic [wntm_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tuser,   // [0] matched
    input  logic                           cfg_wr_en,
    input  logic [wntm_pkg::GAP_W-1:0]     cfg_wr_data
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = $clog2(TABLE_DEPTH + LOOK_AHEAD + 1);
    localparam int SW = wntm_pkg::STAMP_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]                   state_reg, state_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [IW-1:0]                cursor_reg, cursor_next;
    logic [CW-1:0]                addr_reg, addr_next;
    logic [CW-1:0]                end_reg, end_next;
    logic [SW-1:0]                color_reg;
    logic [wntm_pkg::GAP_W-1:0]   max_gap_reg;
    logic                         rd_valid_reg;
    logic [IW-1:0]                rd_idx_reg;

    logic                         accept;
    logic [wntm_pkg::CMD_W-1:0]   cmd;
    logic [SW-1:0]                stamp;
    logic                         wr_en;
    logic                         issue;
    logic                         start_search;
    logic [IW-1:0]                win_start;
    logic [EW-1:0]                win_end_raw;
    logic [SW-1:0]                rd_data;
    wntm_pkg::pick_ctl_t          pick_ctl;
    logic                         pick_busy;
    logic                         best_have;
    logic [IW-1:0]                best_idx;
    logic [SW-1:0]                best_stamp;
    logic [SW-1:0]                best_gap;
    logic                         is_match;
    logic                         out_free;
    logic                         load_out;
    logic [wntm_pkg::OUT_IDX_W+IW-1:0] idx_wide;

    logic                           m_tvalid_reg;
    logic                           m_matched_reg;
    logic [wntm_pkg::OUT_IDX_W-1:0] m_idx_reg;
    logic [SW-1:0]                  m_stamp_reg;
    logic [SW-1:0]                  m_gap_reg;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign cmd      = s_tuser;
    assign stamp    = s_tdata[SW-1:0];

    assign wr_en = accept && (cmd == wntm_pkg::CMD_APPEND) && (count_reg < CW'(TABLE_DEPTH));
    assign start_search = accept && (cmd == wntm_pkg::CMD_MATCH);
    assign issue = (state_reg == ST_SCAN) && (addr_reg < end_reg);

    // window bounds from the current cursor
    always_comb
    begin
        if (cursor_reg > IW'(LOOK_BEHIND))
        begin
            win_start = cursor_reg - IW'(LOOK_BEHIND);
        end
        else
        begin
            win_start = '0;
        end
        win_end_raw = EW'(cursor_reg) + EW'(LOOK_AHEAD);
    end

    assign out_free = !m_tvalid_reg || m_tready;
    assign load_out = (state_reg == ST_FINISH) && out_free;
    assign is_match = best_have && (best_gap <= SW'(max_gap_reg));

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        cursor_next = cursor_reg;
        addr_next   = addr_reg;
        end_next    = end_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        wntm_pkg::CMD_CLEAR:
                        begin
                            count_next  = '0;
                            cursor_next = '0;
                        end
                        wntm_pkg::CMD_APPEND:
                        begin
                            if (wr_en)
                            begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        wntm_pkg::CMD_MATCH:
                        begin
                            addr_next = CW'(win_start);
                            if (win_end_raw > EW'(count_reg))
                            begin
                                end_next = count_reg;
                            end
                            else
                            begin
                                end_next = CW'(win_end_raw);
                            end
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    addr_next = addr_reg + 1'b1;
                end
                else if (!rd_valid_reg && !pick_busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    if (is_match)
                    begin
                        cursor_next = best_idx;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            cursor_reg   <= '0;
            addr_reg     <= '0;
            end_reg      <= '0;
            rd_valid_reg <= 1'b0;
            max_gap_reg  <= wntm_pkg::MAX_GAP_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            cursor_reg   <= cursor_next;
            addr_reg     <= addr_next;
            end_reg      <= end_next;
            rd_valid_reg <= issue;
            if (cfg_wr_en)
            begin
                max_gap_reg <= cfg_wr_data;
            end
            if (load_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= addr_reg[IW-1:0];
        if (start_search)
        begin
            color_reg <= stamp;
        end
        if (load_out)
        begin
            m_matched_reg <= is_match;
            m_idx_reg     <= idx_wide[wntm_pkg::OUT_IDX_W-1:0];
            m_stamp_reg   <= best_stamp;
            m_gap_reg     <= best_gap;
        end
    end

    assign idx_wide = {{wntm_pkg::OUT_IDX_W{1'b0}}, best_idx};

    assign pick_ctl.start = start_search;
    assign pick_ctl.valid = rd_valid_reg;

    wntm_table #(
        .DEPTH (TABLE_DEPTH),
        .IW    (IW)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IW-1:0]),
        .wr_data (stamp),
        .rd_en   (issue),
        .rd_addr (addr_reg[IW-1:0]),
        .rd_data (rd_data)
    );

    wntm_pick #(
        .IW (IW)
    ) u_pick (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (pick_ctl),
        .rd_idx     (rd_idx_reg),
        .rd_data    (rd_data),
        .color      (color_reg),
        .busy       (pick_busy),
        .have       (best_have),
        .best_idx   (best_idx),
        .best_stamp (best_stamp),
        .best_gap   (best_gap)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_matched_reg;
    assign m_tdata  = {{(wntm_pkg::M_TDATA_W - wntm_pkg::OUT_IDX_W - 2 * SW){1'b0}},
                       m_gap_reg, m_stamp_reg, m_idx_reg};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_cursor_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) ? (cursor_reg == '0) : (CW'(cursor_reg) < count_reg))
        else $error("cursor outside filled table");

    a_idle_no_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!rd_valid_reg && !pick_busy))
        else $error("table read in flight while idle");

    a_scan_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        issue |-> (addr_reg < count_reg))
        else $error("scan read beyond filled entries");

endmodule

// ===== dv/windowed_nearest_timestamp_matcher_tb.sv =====
// Self-checking testbench for the windowed nearest-timestamp matcher.
`timescale 1ns / 100ps

module windowed_nearest_timestamp_matcher_tb;

    localparam logic [wntm_pkg::STAMP_W-1:0] STAMP_MAX = {wntm_pkg::STAMP_W{1'b1}};
    localparam logic [wntm_pkg::CMD_W-1:0]   CMD_SPARE = 2'd3;  // unused command code
    localparam int                 SLACK_CYC  = 48;    // longer than a full-window scan
    localparam int                 LIMIT_CYC  = 1200000;
    localparam int                 FRAME_STEP = 33333; // ~30 fps in microseconds
    localparam int                 LONG_FILL  = 300;

    typedef struct packed {
        logic                           matched;
        logic [wntm_pkg::OUT_IDX_W-1:0] index;
        logic [wntm_pkg::STAMP_W-1:0]   dstamp;
        logic [wntm_pkg::STAMP_W-1:0]   gap;
    } pair_result_t;

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [wntm_pkg::S_TDATA_W-1:0] s_tdata;
    logic [wntm_pkg::CMD_W-1:0]     s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [wntm_pkg::M_TDATA_W-1:0] m_tdata;
    logic                           m_tuser;
    logic                           cfg_wr_en;
    logic [wntm_pkg::GAP_W-1:0]     cfg_wr_data;

    // predictor state
    logic [wntm_pkg::STAMP_W-1:0] depth_tbl [wntm_pkg::TABLE_DEPTH_DEF];
    int unsigned                  tbl_count;
    int unsigned                  tbl_cursor;
    logic [wntm_pkg::GAP_W-1:0]   gap_limit;
    pair_result_t                 pending_pairs [$];

    int  err_count;
    int  words_sent;
    int  pairs_checked;
    int  pairs_matched;
    bit  tx_idle_on;
    bit  rx_idle_on;
    int  hold_len;
    int  hold_tag;

    windowed_nearest_timestamp_matcher DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    task automatic report_error(input string msg);
        if (err_count < 40)
            $display("ERROR at %0t ns: %s", $time, msg);
        err_count++;
    endtask

    function automatic logic [wntm_pkg::STAMP_W-1:0] rand_stamp();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[wntm_pkg::STAMP_W-1:0];
    endfunction

    // Apply one accepted word to the predictor; a match queues its expected pair.
    function automatic void track_word(input logic [wntm_pkg::CMD_W-1:0] cmd,
                                       input logic [wntm_pkg::STAMP_W-1:0] stamp);
        int unsigned                  lo;
        int unsigned                  hi;
        bit                           have;
        logic [wntm_pkg::STAMP_W-1:0] d;
        pair_result_t                 r;
        r = '0;
        have = 1'b0;
        case (cmd)
            wntm_pkg::CMD_CLEAR:
            begin
                tbl_count  = 0;
                tbl_cursor = 0;
            end
            wntm_pkg::CMD_APPEND:
            begin
                if (tbl_count < wntm_pkg::TABLE_DEPTH_DEF)
                begin
                    depth_tbl[tbl_count] = stamp;
                    tbl_count++;
                end
            end
            wntm_pkg::CMD_MATCH:
            begin
                lo = (tbl_cursor > wntm_pkg::LOOK_BEHIND_DEF)
                         ? tbl_cursor - wntm_pkg::LOOK_BEHIND_DEF : 0;
                hi = tbl_cursor + wntm_pkg::LOOK_AHEAD_DEF;
                if (hi > tbl_count)
                    hi = tbl_count;
                for (int unsigned i = lo; i < hi; i++)
                begin
                    d = (stamp >= depth_tbl[i]) ? stamp - depth_tbl[i] : depth_tbl[i] - stamp;
                    // strict less-than keeps the lowest index on a tie
                    if (!have || d < r.gap)
                    begin
                        have     = 1'b1;
                        r.gap    = d;
                        r.index  = i[wntm_pkg::OUT_IDX_W-1:0];
                        r.dstamp = depth_tbl[i];
                    end
                end
                if (have && r.gap <= {{(wntm_pkg::STAMP_W-wntm_pkg::GAP_W){1'b0}}, gap_limit})
                begin
                    r.matched  = 1'b1;
                    tbl_cursor = r.index;
                end
                pending_pairs = {pending_pairs, r};
            end
            default: ;
        endcase
    endfunction

    // Offer one word, with an occasional idle burst ahead of it; returns at the
    // falling edge after acceptance with tvalid low.
    task automatic send_word(input logic [wntm_pkg::CMD_W-1:0] cmd,
                             input logic [wntm_pkg::STAMP_W-1:0] stamp);
        int idle_len;
        if (tx_idle_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid = 1'b0;
            idle_len = $urandom_range(1, 8);
            repeat (idle_len) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = {{(wntm_pkg::S_TDATA_W-wntm_pkg::STAMP_W){1'b0}}, stamp};
        do
            @(posedge clk);
        while (!s_tready);
        track_word(cmd, stamp);
        words_sent++;
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    // Wait for every expected pair, then let a possible scan in flight finish.
    task automatic wait_drain();
        while (pending_pairs.size() != 0)
            @(posedge clk);
        repeat (SLACK_CYC) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_max_gap(input logic [wntm_pkg::GAP_W-1:0] value);
        wait_drain();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
        gap_limit   = value;
    endtask

    // Receiver: random stall bursts, plus long hold-offs requested by the tests.
    initial
    begin
        int stall_left;
        int hold_left;
        int seen_tag;
        stall_left = 0;
        hold_left  = 0;
        seen_tag   = 0;
        m_tready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_tag != seen_tag)
            begin
                seen_tag  = hold_tag;
                hold_left = hold_len;
            end
            if (hold_left > 0)
            begin
                m_tready = 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                m_tready = 1'b0;
                stall_left--;
            end
            else if (rx_idle_on && $urandom_range(0, 6) == 0)
            begin
                m_tready   = 1'b0;
                stall_left = $urandom_range(1, 8) - 1;
            end
            else
                m_tready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        pair_result_t got;
        pair_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.matched = m_tuser;
            got.index   = m_tdata[11:0];
            got.dstamp  = m_tdata[63:12];
            got.gap     = m_tdata[115:64];
            if (pending_pairs.size() == 0)
                report_error($sformatf("unexpected pair: matched %0b index %0d stamp %0d gap %0d",
                                       got.matched, got.index, got.dstamp, got.gap));
            else
            begin
                want = pending_pairs.pop_front();
                pairs_checked++;
                if (want.matched)
                    pairs_matched++;
                if (got !== want)
                    report_error($sformatf({"pair mismatch: got %0b/%0d/%0d/%0d, ",
                                            "expected %0b/%0d/%0d/%0d"},
                                           got.matched, got.index, got.dstamp, got.gap,
                                           want.matched, want.index, want.dstamp, want.gap));
            end
        end
    end

    // Empty window, unused command, ties, both stamp extremes and the gap limits.
    task automatic test_directed();
        send_word(wntm_pkg::CMD_MATCH, 52'd123);
        send_word(CMD_SPARE, STAMP_MAX);
        send_word(wntm_pkg::CMD_APPEND, 52'd1000);
        send_word(wntm_pkg::CMD_APPEND, 52'd5000);
        send_word(wntm_pkg::CMD_APPEND, 52'd5000);
        send_word(wntm_pkg::CMD_APPEND, 52'd9000);
        send_word(wntm_pkg::CMD_APPEND, STAMP_MAX);
        send_word(wntm_pkg::CMD_MATCH, 52'd5000);
        send_word(wntm_pkg::CMD_MATCH, 52'd7000);
        send_word(wntm_pkg::CMD_MATCH, 52'd0);
        send_word(wntm_pkg::CMD_MATCH, STAMP_MAX);
        send_word(wntm_pkg::CMD_MATCH, 52'h8_0000_0000_0000);
        write_max_gap('0);
        send_word(wntm_pkg::CMD_MATCH, 52'd9001);
        send_word(wntm_pkg::CMD_MATCH, 52'd9000);
        write_max_gap('1);
        send_word(wntm_pkg::CMD_MATCH, 52'h1_0000_0000 + 52'd8999);
        send_word(wntm_pkg::CMD_MATCH, 52'h1_0000_0000 + 52'd9000);
        // out-of-order entry is scanned like any other
        send_word(wntm_pkg::CMD_APPEND, 52'd500);
        send_word(wntm_pkg::CMD_MATCH, 52'd400);
        send_word(wntm_pkg::CMD_CLEAR, rand_stamp());
        send_word(wntm_pkg::CMD_MATCH, 52'd7);
        send_word(wntm_pkg::CMD_APPEND, 52'd7);
        send_word(wntm_pkg::CMD_MATCH, 52'd7);
        write_max_gap(wntm_pkg::MAX_GAP_RESET);
    endtask

    // Look-behind and look-ahead clipping as the cursor moves both ways.
    task automatic test_window_edges();
        send_word(wntm_pkg::CMD_CLEAR, '0);
        for (int i = 0; i < 40; i++)
            send_word(wntm_pkg::CMD_APPEND, 52'(i * 100));
        send_word(wntm_pkg::CMD_MATCH, 52'd3900);
        send_word(wntm_pkg::CMD_MATCH, 52'd1900);
        send_word(wntm_pkg::CMD_MATCH, 52'd0);
        send_word(wntm_pkg::CMD_MATCH, 52'd3900);
        send_word(wntm_pkg::CMD_MATCH, 52'd3900);
        send_word(wntm_pkg::CMD_MATCH, 52'd0);
        wait_drain();
    endtask

    // Long table: walk the cursor to the top, then an out-of-order tail entry.
    task automatic test_long_table();
        int unsigned target;
        send_word(wntm_pkg::CMD_CLEAR, '0);
        for (int i = 0; i < LONG_FILL; i++)
            send_word(wntm_pkg::CMD_APPEND, 52'd1000 + 52'(i) * FRAME_STEP);
        while (tbl_cursor < LONG_FILL - 1)
        begin
            target = tbl_cursor + wntm_pkg::LOOK_AHEAD_DEF - 1;
            if (target > LONG_FILL - 1)
                target = LONG_FILL - 1;
            send_word(wntm_pkg::CMD_MATCH,
                      depth_tbl[target] + 52'($urandom_range(0, 5000)));
        end
        send_word(wntm_pkg::CMD_MATCH, STAMP_MAX);
        send_word(wntm_pkg::CMD_APPEND, 52'd5);
        send_word(wntm_pkg::CMD_MATCH, 52'd5);
        wait_drain();
    endtask

    // One recording: clear, then depth frames with color frames near them, some noise.
    task automatic run_stream(input int n_frames);
        logic [wntm_pkg::STAMP_W-1:0] base;
        logic [wntm_pkg::STAMP_W-1:0] frames [$];
        logic [wntm_pkg::STAMP_W-1:0] stamp;
        int                           j;
        int                           off;
        send_word(wntm_pkg::CMD_CLEAR, rand_stamp());
        base = rand_stamp() >> $urandom_range(1, 40);
        for (int f = 0; f < n_frames; f++)
        begin
            stamp = base + 52'(f) * FRAME_STEP + 52'($urandom_range(0, 2000));
            frames = {frames, stamp};
            send_word(wntm_pkg::CMD_APPEND, stamp);
            if (f >= 1 && $urandom_range(0, 3) != 0)
            begin
                j = f - $urandom_range(0, (f < 3) ? f : 3);
                if ($urandom_range(0, 9) == 0)
                    off = int'($urandom_range(0, 400000)) - 200000;
                else
                    off = int'($urandom_range(0, 44000)) - 22000;
                send_word(wntm_pkg::CMD_MATCH, frames[j] + 52'(signed'(off)));
            end
            if ($urandom_range(0, 11) == 0)
            begin
                case ($urandom_range(0, 4))
                    0: send_word(CMD_SPARE, rand_stamp());
                    1: send_word(wntm_pkg::CMD_MATCH, rand_stamp());
                    2: send_word(wntm_pkg::CMD_APPEND, rand_stamp());
                    3: send_word(wntm_pkg::CMD_MATCH, base + 52'($urandom));
                    default:
                    begin
                        send_word(wntm_pkg::CMD_CLEAR, rand_stamp());
                        frames.delete();
                        base = stamp;
                        f = -1;
                        n_frames = n_frames - 1;
                    end
                endcase
            end
        end
    endtask

    task automatic test_random_streams(input int n_words);
        int                         stop_at;
        int                         phase;
        logic [wntm_pkg::GAP_W-1:0] setting;
        stop_at = words_sent + n_words;
        phase   = 0;
        while (words_sent < stop_at)
        begin
            case (phase % 6)
                0: setting = wntm_pkg::MAX_GAP_RESET;
                1: setting = '0;
                2: setting = '1;
                3: setting = $urandom;
                4: setting = $urandom_range(0, 40000);
                default: setting = $urandom_range(1000, 15000);
            endcase
            write_max_gap(setting);
            for (int k = 0; k < 4 && words_sent < stop_at; k++)
                run_stream(($urandom_range(0, 7) == 0) ? $urandom_range(60, 120)
                                                       : $urandom_range(3, 45));
            phase++;
        end
        write_max_gap(wntm_pkg::MAX_GAP_RESET);
    endtask

    // Long output hold-off while matches keep coming, then a full drain.
    task automatic test_backpressure();
        send_word(wntm_pkg::CMD_CLEAR, '0);
        for (int i = 0; i < 40; i++)
            send_word(wntm_pkg::CMD_APPEND, 52'd777 + 52'(i) * FRAME_STEP);
        @(posedge clk);
        hold_len = 400;
        hold_tag++;
        @(negedge clk);
        for (int i = 0; i < 30; i++)
            send_word(wntm_pkg::CMD_MATCH, 52'd777 + 52'($urandom_range(0, 39)) * FRAME_STEP
                                           + 52'($urandom_range(0, 30000)));
        wait_drain();
    endtask

    // Closing stretch at full rate on both sides.
    task automatic test_full_rate(input int n_words);
        int stop_at;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        stop_at = words_sent + n_words;
        while (words_sent < stop_at)
            run_stream($urandom_range(10, 50));
    endtask

    initial
    begin
        #(LIMIT_CYC * 20);
        $display("windowed_nearest_timestamp_matcher_tb: done, errors");
        $finish;
    end

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = wntm_pkg::CMD_CLEAR;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        tbl_count   = 0;
        tbl_cursor  = 0;
        gap_limit   = wntm_pkg::MAX_GAP_RESET;
        err_count   = 0;
        words_sent  = 0;
        pairs_checked = 0;
        pairs_matched = 0;
        tx_idle_on  = 1'b1;
        rx_idle_on  = 1'b1;
        hold_len    = 0;
        hold_tag    = 0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_window_edges();
        test_long_table();
        test_random_streams(900);
        test_backpressure();
        test_full_rate(150);
        wait_drain();

        if (pending_pairs.size() != 0)
            report_error($sformatf("%0d expected pairs never arrived", pending_pairs.size()));
        $display("Sent %0d words: empty and clipped windows, a long cursor walk, max_gap 0..2^32-1.",
                 words_sent);
        $display("Checked %0d color lookups, %0d of them within max_gap.",
                 pairs_checked, pairs_matched);
        if (err_count == 0)
            $display("windowed_nearest_timestamp_matcher_tb: done, clean");
        else
            $display("windowed_nearest_timestamp_matcher_tb: done, errors");
        $finish;
    end

endmodule
